// ===== design/rmgl_pkg.sv =====
// Shared widths and codes for the range max gain and loss block.
// No dependencies; imported by range_max_gain_and_loss.
`default_nettype none

package rmgl_pkg;

    // Field widths fixed by the interface
    localparam int PRICE_W  = 31;
    localparam int IDX_W    = 10;
    localparam int SELL_W   = 11;
    localparam int STATUS_W = 2;

    // Default store depth
    localparam int DEFAULT_STORE_DEPTH = 1024;

    // Request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

`default_nettype wire

// ===== design/range_max_gain_and_loss.sv =====
// Append-only price store with range queries for largest rise and largest fall.
// A push is written at its transfer; a dropped push or bad range raises done next cycle.
// A query over N = last-first+1 entries reads them through the single read port,
// one stored price a cycle; done rises when the last one is processed, busy until then.
// No transfer is taken while busy; else one push per cycle. The receiver cannot stall.
// Reset (rst_n, async, low): store empty, no scan in progress; memory contents undefined.
`default_nettype none

module range_max_gain_and_loss #(
    parameter int STORE_DEPTH = rmgl_pkg::DEFAULT_STORE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic                          req_type,
    input  wire logic [rmgl_pkg::PRICE_W-1:0]  price,
    input  wire logic [rmgl_pkg::IDX_W-1:0]    first_index,
    input  wire logic [rmgl_pkg::IDX_W-1:0]    last_index,
    output      logic                          done,
    output      logic [rmgl_pkg::STATUS_W-1:0] status,
    output      logic                          gain_found,
    output      logic [rmgl_pkg::PRICE_W-1:0]  gain_amount,
    output      logic [rmgl_pkg::IDX_W-1:0]    gain_buy_index,
    output      logic [rmgl_pkg::SELL_W-1:0]   gain_sell_index,
    output      logic                          loss_found,
    output      logic [rmgl_pkg::PRICE_W-1:0]  loss_amount,
    output      logic [rmgl_pkg::IDX_W-1:0]    loss_buy_index,
    output      logic [rmgl_pkg::SELL_W-1:0]   loss_sell_index
);
    import rmgl_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W + 1;

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [ADDR_W-1:0]     first_reg;
    logic [ADDR_W-1:0]     last_reg;
    logic                  issue_reg;
    logic                  dv_reg;
    logic [ADDR_W-1:0]     d_idx_reg;
    logic [PRICE_W-1:0]    rd_data_reg;

    // Result registers
    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  gain_found_reg;
    logic [PRICE_W-1:0]    gain_amount_reg;
    logic [IDX_W-1:0]      gain_buy_reg;
    logic [SELL_W-1:0]     gain_sell_reg;
    logic                  loss_found_reg;
    logic [PRICE_W-1:0]    loss_amount_reg;
    logic [IDX_W-1:0]      loss_buy_reg;
    logic [SELL_W-1:0]     loss_sell_reg;

    // Scan trackers
    logic [PRICE_W-1:0]    lo_price_reg, lo_price_next;
    logic [PRICE_W-1:0]    hi_price_reg, hi_price_next;
    logic [ADDR_W-1:0]     lo_idx_reg, lo_idx_next;
    logic [ADDR_W-1:0]     hi_idx_reg, hi_idx_next;
    logic [PRICE_W-1:0]    g_amt_reg, g_amt_next;
    logic [IDX_W-1:0]      g_buy_reg, g_buy_next;
    logic [SELL_W-1:0]     g_sell_reg, g_sell_next;
    logic [PRICE_W-1:0]    l_amt_reg, l_amt_next;
    logic [IDX_W-1:0]      l_buy_reg, l_buy_next;
    logic [SELL_W-1:0]     l_sell_reg, l_sell_next;

    logic [PRICE_W-1:0]    price_mem [STORE_DEPTH];

    logic                  accept;
    logic                  push_we;
    logic                  store_full;
    logic                  range_bad;
    logic                  scan_last;
    logic                  is_first;
    logic [PRICE_W-1:0]    gdiff;
    logic [PRICE_W-1:0]    ldiff;
    logic [SELL_W-1:0]     first_sell;

    assign accept     = start && !busy;
    assign store_full = (count_reg == CNT_W'(STORE_DEPTH));
    assign push_we    = accept && (req_type == REQ_PUSH) && !store_full;
    assign range_bad  = (CMP_W'(first_index) >= CMP_W'(count_reg))
                     || (CMP_W'(last_index) >= CMP_W'(count_reg))
                     || (first_index > last_index);
    assign scan_last  = dv_reg && (d_idx_reg == last_reg);
    assign is_first   = (d_idx_reg == first_reg);
    assign first_sell = SELL_W'(first_index) + SELL_W'(1);

    assign busy = (state_reg != ST_IDLE);

    // Price store: one write port for pushes, one registered read port for scans
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            price_mem[count_reg[ADDR_W-1:0]] <= price;
        end
        rd_data_reg <= price_mem[rd_addr_reg];
    end

    // One scan step on the price just read
    always_comb
    begin
        lo_price_next = lo_price_reg;
        hi_price_next = hi_price_reg;
        lo_idx_next   = lo_idx_reg;
        hi_idx_next   = hi_idx_reg;
        g_amt_next    = g_amt_reg;
        g_buy_next    = g_buy_reg;
        g_sell_next   = g_sell_reg;
        l_amt_next    = l_amt_reg;
        l_buy_next    = l_buy_reg;
        l_sell_next   = l_sell_reg;
        gdiff         = rd_data_reg - lo_price_reg;
        ldiff         = hi_price_reg - rd_data_reg;
        if (dv_reg)
        begin
            if (is_first)
            begin
                lo_price_next = rd_data_reg;
                hi_price_next = rd_data_reg;
                lo_idx_next   = d_idx_reg;
                hi_idx_next   = d_idx_reg;
            end
            else
            begin
                // Gain wins over loss in the same step; strict compare keeps earliest pair
                if ((rd_data_reg > lo_price_reg) && (gdiff > g_amt_reg))
                begin
                    g_amt_next  = gdiff;
                    g_buy_next  = IDX_W'(lo_idx_reg);
                    g_sell_next = SELL_W'(d_idx_reg);
                end
                else if ((rd_data_reg < hi_price_reg) && (ldiff > l_amt_reg))
                begin
                    l_amt_next  = ldiff;
                    l_buy_next  = IDX_W'(hi_idx_reg);
                    l_sell_next = SELL_W'(d_idx_reg);
                end
                if (rd_data_reg < lo_price_reg)
                begin
                    lo_price_next = rd_data_reg;
                    lo_idx_next   = d_idx_reg;
                end
                if (rd_data_reg > hi_price_reg)
                begin
                    hi_price_next = rd_data_reg;
                    hi_idx_next   = d_idx_reg;
                end
            end
        end
    end

    // Scan tracker registers; gain and loss are seeded with the defaults at every accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g_amt_reg  <= '0;
            g_buy_reg  <= first_index;
            g_sell_reg <= first_sell;
            l_amt_reg  <= '0;
            l_buy_reg  <= first_index;
            l_sell_reg <= first_sell;
        end
        else
        begin
            g_amt_reg  <= g_amt_next;
            g_buy_reg  <= g_buy_next;
            g_sell_reg <= g_sell_next;
            l_amt_reg  <= l_amt_next;
            l_buy_reg  <= l_buy_next;
            l_sell_reg <= l_sell_next;
        end
        lo_price_reg <= lo_price_next;
        hi_price_reg <= hi_price_next;
        lo_idx_reg   <= lo_idx_next;
        hi_idx_reg   <= hi_idx_next;
    end

    // Control state, read sequencing and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            rd_addr_reg     <= '0;
            first_reg       <= '0;
            last_reg        <= '0;
            issue_reg       <= 1'b0;
            dv_reg          <= 1'b0;
            d_idx_reg       <= '0;
            done_reg        <= 1'b0;
            status_reg      <= STATUS_OK;
            gain_found_reg  <= 1'b0;
            gain_amount_reg <= '0;
            gain_buy_reg    <= '0;
            gain_sell_reg   <= '0;
            loss_found_reg  <= 1'b0;
            loss_amount_reg <= '0;
            loss_buy_reg    <= '0;
            loss_sell_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            dv_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_PUSH)
                        begin
                            if (store_full)
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= STATUS_FULL;
                                gain_found_reg  <= 1'b0;
                                gain_amount_reg <= '0;
                                gain_buy_reg    <= '0;
                                gain_sell_reg   <= '0;
                                loss_found_reg  <= 1'b0;
                                loss_amount_reg <= '0;
                                loss_buy_reg    <= '0;
                                loss_sell_reg   <= '0;
                            end
                            else
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        else if (range_bad)
                        begin
                            done_reg        <= 1'b1;
                            status_reg      <= STATUS_BAD_RANGE;
                            gain_found_reg  <= 1'b0;
                            gain_amount_reg <= '0;
                            gain_buy_reg    <= '0;
                            gain_sell_reg   <= '0;
                            loss_found_reg  <= 1'b0;
                            loss_amount_reg <= '0;
                            loss_buy_reg    <= '0;
                            loss_sell_reg   <= '0;
                        end
                        else
                        begin
                            state_reg   <= ST_SCAN;
                            rd_addr_reg <= ADDR_W'(first_index);
                            first_reg   <= ADDR_W'(first_index);
                            last_reg    <= ADDR_W'(last_index);
                            issue_reg   <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // Issue one read a cycle until the last address
                    if (issue_reg)
                    begin
                        dv_reg    <= 1'b1;
                        d_idx_reg <= rd_addr_reg;
                        if (rd_addr_reg == last_reg)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                        end
                    end
                    // Last price processed: publish the result
                    if (scan_last)
                    begin
                        state_reg       <= ST_IDLE;
                        done_reg        <= 1'b1;
                        status_reg      <= STATUS_OK;
                        gain_found_reg  <= (g_amt_next != '0);
                        gain_amount_reg <= g_amt_next;
                        gain_buy_reg    <= g_buy_next;
                        gain_sell_reg   <= g_sell_next;
                        loss_found_reg  <= (l_amt_next != '0);
                        loss_amount_reg <= l_amt_next;
                        loss_buy_reg    <= l_buy_next;
                        loss_sell_reg   <= l_sell_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign gain_found      = gain_found_reg;
    assign gain_amount     = gain_amount_reg;
    assign gain_buy_index  = gain_buy_reg;
    assign gain_sell_index = gain_sell_reg;
    assign loss_found      = loss_found_reg;
    assign loss_amount     = loss_amount_reg;
    assign loss_buy_index  = loss_buy_reg;
    assign loss_sell_index = loss_sell_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a scan is running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("entry count beyond store depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted push did not advance the entry count");

    a_dv_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == ST_SCAN))
        else $error("read data valid outside a scan");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_addr_reg <= last_reg) && (rd_addr_reg >= first_reg))
        else $error("scan read address left the query range");

endmodule

`default_nettype wire

// ===== bench/range_max_gain_and_loss_tb.sv =====
// Self-checking bench for range_max_gain_and_loss: pushes prices, queries ranges and
// predicts each status, gain and loss result from a ledger kept inside the bench.
// Depends on rmgl_pkg (widths and codes) and the range_max_gain_and_loss RTL only.
`default_nettype none

module range_max_gain_and_loss_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmgl_pkg::*;

    localparam int DEPTH = DEFAULT_STORE_DEPTH;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
    localparam int MAX_PRINTED = 100;

    // One result as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                gain_found;
        logic [PRICE_W-1:0]  gain_amount;
        logic [IDX_W-1:0]    gain_buy;
        logic [SELL_W-1:0]   gain_sell;
        logic                loss_found;
        logic [PRICE_W-1:0]  loss_amount;
        logic [IDX_W-1:0]    loss_buy;
        logic [SELL_W-1:0]   loss_sell;
    } scan_result_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                req_type    = REQ_PUSH;
    logic [PRICE_W-1:0]  price       = '0;
    logic [IDX_W-1:0]    first_index = '0;
    logic [IDX_W-1:0]    last_index  = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                gain_found;
    logic [PRICE_W-1:0]  gain_amount;
    logic [IDX_W-1:0]    gain_buy_index;
    logic [SELL_W-1:0]   gain_sell_index;
    logic                loss_found;
    logic [PRICE_W-1:0]  loss_amount;
    logic [IDX_W-1:0]    loss_buy_index;
    logic [SELL_W-1:0]   loss_sell_index;

    // Bench copy of the price store
    logic [PRICE_W-1:0]  ledger [DEPTH];
    int unsigned         ledger_len = 0;
    scan_result_t        owed_results [$];

    int mismatches      = 0;
    int pushes_sent     = 0;
    int queries_sent    = 0;
    int results_checked = 0;
    int drops_owed      = 0;
    int idle_pct        = 0;

    range_max_gain_and_loss uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a result never shows up
    initial
    begin
        #(100_000_000);
        $display("Timeout with %0d results still owed", owed_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Walk one valid range: running minimum for the rise, running maximum for the fall
    function automatic scan_result_t scan_range(input int unsigned f, input int unsigned l);
        scan_result_t r;
        longint       best_rise;
        longint       best_fall;
        longint       p;
        longint       d_lo;
        longint       d_hi;
        int unsigned  lo;
        int unsigned  hi;
        r = '0;
        r.status = STATUS_OK;
        best_rise = 0;
        best_fall = 0;
        r.gain_buy  = IDX_W'(f);
        r.gain_sell = SELL_W'(f + 1);
        r.loss_buy  = IDX_W'(f);
        r.loss_sell = SELL_W'(f + 1);
        lo = f;
        hi = f;
        for (int unsigned i = f + 1; i <= l; i++)
        begin
            p    = longint'(ledger[i]);
            d_lo = p - longint'(ledger[lo]);
            d_hi = p - longint'(ledger[hi]);
            // strict compares keep the earliest pair on ties
            if (d_lo > best_rise)
            begin
                best_rise   = d_lo;
                r.gain_buy  = IDX_W'(lo);
                r.gain_sell = SELL_W'(i);
            end
            else if (d_hi < best_fall)
            begin
                best_fall   = d_hi;
                r.loss_buy  = IDX_W'(hi);
                r.loss_sell = SELL_W'(i);
            end
            if (p < longint'(ledger[lo])) lo = i;
            if (p > longint'(ledger[hi])) hi = i;
        end
        r.gain_found  = (best_rise > 0);
        r.gain_amount = PRICE_W'(best_rise);
        r.loss_found  = (best_fall < 0);
        r.loss_amount = PRICE_W'(-best_fall);
        return r;
    endfunction

    // Update the ledger for one accepted transfer and queue the result it owes, if any
    function automatic void apply_request(input logic rt, input logic [PRICE_W-1:0] p,
                                          input logic [IDX_W-1:0] f,
                                          input logic [IDX_W-1:0] l);
        scan_result_t r;
        r = '0;
        if (rt == REQ_PUSH)
        begin
            if (ledger_len >= DEPTH)
            begin
                r.status = STATUS_FULL;
                owed_results.push_back(r);
                drops_owed++;
            end
            else
            begin
                ledger[ledger_len] = p;
                ledger_len++;
            end
        end
        else if (f >= ledger_len || l >= ledger_len || f > l)
        begin
            r.status = STATUS_BAD_RANGE;
            owed_results.push_back(r);
        end
        else
            owed_results.push_back(scan_range(f, l));
    endfunction

    // Compare one strobed result against the oldest owed one
    task automatic check_result();
        scan_result_t want;
        if (owed_results.size() == 0)
        begin
            flag_mismatch("result with none owed, status", status, 0);
            return;
        end
        want = owed_results.pop_front();
        results_checked++;
        if (status !== want.status)
            flag_mismatch("status", status, want.status);
        if (gain_found !== want.gain_found)
            flag_mismatch("gain_found", gain_found, want.gain_found);
        if (gain_amount !== want.gain_amount)
            flag_mismatch("gain_amount", gain_amount, want.gain_amount);
        if (gain_buy_index !== want.gain_buy)
            flag_mismatch("gain_buy_index", gain_buy_index, want.gain_buy);
        if (gain_sell_index !== want.gain_sell)
            flag_mismatch("gain_sell_index", gain_sell_index, want.gain_sell);
        if (loss_found !== want.loss_found)
            flag_mismatch("loss_found", loss_found, want.loss_found);
        if (loss_amount !== want.loss_amount)
            flag_mismatch("loss_amount", loss_amount, want.loss_amount);
        if (loss_buy_index !== want.loss_buy)
            flag_mismatch("loss_buy_index", loss_buy_index, want.loss_buy);
        if (loss_sell_index !== want.loss_sell)
            flag_mismatch("loss_sell_index", loss_sell_index, want.loss_sell);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            check_result();
    end

    // One transfer; start stays high so a following item can go back to back
    task automatic send_item(input logic rt, input logic [PRICE_W-1:0] p,
                             input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] l);
        start       <= 1'b1;
        req_type    <= rt;
        price       <= p;
        first_index <= f;
        last_index  <= l;
        do
            @(posedge clk);
        while (busy);
        apply_request(rt, p, f, l);
        if (rt == REQ_PUSH)
            pushes_sent++;
        else
            queries_sent++;
        // each idle cycle is drawn on its own, so idle_pct is a share of cycles
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic push_price(input logic [PRICE_W-1:0] p);
        send_item(REQ_PUSH, p, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic query_range(input int unsigned f, input int unsigned l);
        send_item(REQ_QUERY, PRICE_W'($urandom), IDX_W'(f), IDX_W'(l));
    endtask

    // Hold off new transfers until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix of wide values, small values that tie often, and the extremes
    function automatic logic [PRICE_W-1:0] pick_price();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return PRICE_W'($urandom);
        else if (sel < 8)
            return PRICE_W'($urandom_range(15));
        else if (sel == 8)
            return PRICE_MAX - PRICE_W'($urandom_range(3));
        else
            return PRICE_W'($urandom_range(1));
    endfunction

    // Mostly valid ranges, short spans, now and then a span to the end of the store
    task automatic random_query();
        int unsigned f;
        int unsigned l;
        int unsigned room;
        int          sel;
        sel = $urandom_range(99);
        if (ledger_len == 0 || sel < 15)
            query_range($urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1));
        else if (sel < 20 && ledger_len > 1)
        begin
            // reversed range
            l = $urandom_range(ledger_len - 2);
            f = $urandom_range(l + 1, ledger_len - 1);
            query_range(f, l);
        end
        else
        begin
            f    = $urandom_range(ledger_len - 1);
            room = ledger_len - 1 - f;
            if ($urandom_range(15) == 0)
                l = f + room;
            else
                l = f + (($urandom_range(15) < room) ? $urandom_range(15) : room);
            query_range(f, l);
        end
    endtask

    task automatic random_traffic(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 55)
                push_price(pick_price());
            else
                random_query();
        end
    endtask

    // Empty store, equal neighbors, extreme swings, tie order and bad ranges
    task automatic test_directed();
        idle_pct = 0;
        query_range(0, 0);
        push_price(100);
        push_price(100);
        push_price(0);
        push_price(PRICE_MAX);
        push_price(PRICE_MAX);
        push_price(0);
        push_price(7);
        query_range(0, 0);
        query_range(0, 1);
        query_range(0, 6);
        query_range(4, 6);
        push_price(1);
        push_price(4);
        push_price(1);
        push_price(4);
        query_range(7, 10);
        query_range(3, 2);
        query_range(0, 11);
        query_range(11, 11);
        query_range(DEPTH - 1, DEPTH - 1);
        drain();
    endtask

    task automatic test_random_sender_gaps();
        idle_pct = 21;
        random_traffic(200);
        drain();
        idle_pct = 49;
        random_traffic(200);
        drain();
    endtask

    task automatic test_random_back_to_back();
        idle_pct = 0;
        random_traffic(180);
        drain();
    endtask

    // Fill the store, then dropped pushes and queries that reach the top index
    task automatic test_store_full();
        idle_pct = 21;
        while (ledger_len < DEPTH)
            push_price(pick_price());
        repeat (4) push_price(pick_price());
        query_range(0, DEPTH - 1);
        query_range(DEPTH - 1, DEPTH - 1);
        query_range(DEPTH - 2, DEPTH - 1);
        query_range(DEPTH / 2, DEPTH - 1);
        idle_pct = 0;
        random_traffic(30);
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_sender_gaps();
        test_random_back_to_back();
        test_store_full();

        repeat (10) @(posedge clk);
        $display("Ran %0d pushes and %0d queries, %0d of them ending in a full-store drop;",
                 pushes_sent, queries_sent, drops_owed);
        $display("%0d results compared field by field, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
